/* hw/rtl/smc_pkg.sv */
package smc_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF   = 16;
   localparam int VALUE_BITS_DEF = 32;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths of the channels
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int OCC_W   = 16;
   localparam int TOTAL_W = 20;
   localparam int NMAX_W  = 5;

   // Widest count the accumulator control can carry
   localparam int CNT_FIELD_W = 32;

   // Operation codes; query and the unused code take the default path
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

   typedef struct packed {
      logic                   clear;
      logic                   add;
      logic [CNT_FIELD_W-1:0] count;
   } acc_ctl_type;

endpackage

/* hw/rtl/smc_if.sv */
interface smc_req_if;
   logic                               valid;
   logic                               ready;
   logic        [smc_pkg::KIND_W-1:0]  kind;
   logic signed [smc_pkg::VALUE_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink (input valid, kind, value, output ready);
endinterface

interface smc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [smc_pkg::OCC_W-1:0]    occurrences;
   logic [smc_pkg::TOTAL_W-1:0]  total_size;
   logic [smc_pkg::NMAX_W-1:0]   max_freq_entries;
   logic                         full_drop;

   modport source (output valid, found, occurrences, total_size, max_freq_entries, full_drop,
                   input ready);
   modport sink (input valid, found, occurrences, total_size, max_freq_entries, full_drop,
                 output ready);
endinterface

interface smc_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/smc_store.sv */
module smc_store #(
   parameter int DEPTH = smc_pkg::CAPACITY_DEF,
   parameter int VAL_W = smc_pkg::VALUE_BITS_DEF,
   parameter int CNT_W = smc_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [VAL_W-1:0]         wr_val,
   input  logic [CNT_W-1:0]         wr_cnt,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [VAL_W-1:0]         rd_val_ff,
   output logic [CNT_W-1:0]         rd_cnt_ff
);

   logic [VAL_W-1:0] val_mem_ff [DEPTH];
   logic [CNT_W-1:0] cnt_mem_ff [DEPTH];

   // Read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      rd_val_ff <= val_mem_ff[rd_addr];
      rd_cnt_ff <= cnt_mem_ff[rd_addr];
      if (wr_en) begin
         val_mem_ff[wr_addr] <= wr_val;
         cnt_mem_ff[wr_addr] <= wr_cnt;
      end
   end

endmodule

/* hw/rtl/smc_freq_acc.sv */
module smc_freq_acc #(
   parameter int CAPACITY   = smc_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = smc_pkg::COUNT_BITS_DEF
) (
   input  logic                                      clock,
   input  smc_pkg::acc_ctl_type                      ctl,
   output logic [COUNT_BITS+$clog2(CAPACITY+1)-1:0]  total_ff,
   output logic [$clog2(CAPACITY+1)-1:0]             nmax_ff
);

   localparam int NW    = $clog2(CAPACITY + 1);
   localparam int TOT_W = COUNT_BITS + NW;

   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] max_ff, max_in;
   logic [TOT_W-1:0]      total_in;
   logic [NW-1:0]         nmax_in;

   always_comb begin
      cnt      = ctl.count[COUNT_BITS-1:0];
      total_in = total_ff;
      max_in   = max_ff;
      nmax_in  = nmax_ff;
      if (ctl.clear) begin
         total_in = '0;
         max_in   = '0;
         nmax_in  = '0;
      end else if (ctl.add) begin
         total_in = total_ff + TOT_W'(cnt);
         // stored counts are never zero, so an empty tally marks the first entry
         if (nmax_ff == '0 || cnt > max_ff) begin
            max_in  = cnt;
            nmax_in = NW'(1);
         end else if (cnt == max_ff) begin
            nmax_in = nmax_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      max_ff   <= max_in;
      nmax_ff  <= nmax_in;
   end

endmodule

/* hw/rtl/sorted_multiset_counter.sv */
// Channel  Dir  Handshake     Payload
// req_if   in   valid/ready   kind, value
// rsp_if   out  valid/ready   found, occurrences, total_size, max_freq_entries, full_drop
// csr_if   in   valid/ready   data (order_descending)
//
// Each item runs a search pass, which reads entries until it finds a match (at most
// CAPACITY entries), and an update pass, which rewrites and tallies every entry of the
// table as it stands after the operation. One memory read port sets the pace.
// req_if.ready is high only while the sequencer is idle; a result held in rsp_if waits
// without blocking the next accept. csr_if is always ready. Synchronous reset empties
// the table at once; no clearing pass.
module sorted_multiset_counter #(
   parameter int CAPACITY   = smc_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = smc_pkg::VALUE_BITS_DEF,
   parameter int COUNT_BITS = smc_pkg::COUNT_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   smc_req_if.sink      req_if,
   smc_rsp_if.source    rsp_if,
   smc_csr_if.sink      csr_if
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int NW       = $clog2(CAPACITY + 1);
   localparam int TOT_W    = COUNT_BITS + NW;
   localparam int CF_W     = smc_pkg::CNT_FIELD_W;
   localparam int EXT_W    = (VALUE_BITS > smc_pkg::VALUE_W) ? VALUE_BITS : smc_pkg::VALUE_W;
   localparam int OCC_X_W  = (COUNT_BITS > smc_pkg::OCC_W) ? COUNT_BITS : smc_pkg::OCC_W;
   localparam int TOT_X_W  = (TOT_W > smc_pkg::TOTAL_W) ? TOT_W : smc_pkg::TOTAL_W;
   localparam int NMAX_X_W = (NW > smc_pkg::NMAX_W) ? NW : smc_pkg::NMAX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PLAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      UPD_KEEP,
      UPD_INSERT,
      UPD_DELETE,
      UPD_CHANGE
   } upd_mode_type;

   typedef struct packed {
      logic                  en;
      logic [AW-1:0]         addr;
      logic [VALUE_BITS-1:0] val;
      logic [COUNT_BITS-1:0] cnt;
   } store_wr_type;

   state_type                     state_ff, state_in;
   upd_mode_type                  mode_ff, mode_in, p_mode, mode_sel;
   logic [smc_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [VALUE_BITS-1:0]         val_ff, val_in;
   logic [NW-1:0]                 n_ff, n_in, idx_ff, idx_in, pos_ff, pos_in, p_n;
   logic [NW-1:0]                 nx, src;
   logic                          found_ff, found_in;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in, new_cnt_ff, new_cnt_in, p_cnt;
   logic [COUNT_BITS-1:0]         occ_ff, occ_in, p_occ;
   logic                          drop_ff, drop_in, p_drop;
   logic                          order_ff, order_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [smc_pkg::OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;
   logic [smc_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [smc_pkg::NMAX_W-1:0]    rsp_nmax_ff, rsp_nmax_in;
   logic                          rsp_drop_ff, rsp_drop_in;

   logic signed [EXT_W-1:0]       req_val_ext;
   logic [OCC_X_W-1:0]            occ_ext;
   logic [TOT_X_W-1:0]            total_ext;
   logic [NMAX_X_W-1:0]           nmax_ext;

   logic [AW-1:0]                 rd_addr;
   logic [VALUE_BITS-1:0]         rd_val;
   logic [COUNT_BITS-1:0]         rd_cnt;
   store_wr_type                  st_wr;
   smc_pkg::acc_ctl_type          acc_ctl;
   logic [TOT_W-1:0]              acc_total;
   logic [NW-1:0]                 acc_nmax;

   logic                          req_fire, eq, goes_after;

   smc_store #(
      .DEPTH (CAPACITY),
      .VAL_W (VALUE_BITS),
      .CNT_W (COUNT_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr.en),
      .wr_addr   (st_wr.addr),
      .wr_val    (st_wr.val),
      .wr_cnt    (st_wr.cnt),
      .rd_addr   (rd_addr),
      .rd_val_ff (rd_val),
      .rd_cnt_ff (rd_cnt)
   );

   smc_freq_acc #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS)
   ) u_acc (
      .clock    (clock),
      .ctl      (acc_ctl),
      .total_ff (acc_total),
      .nmax_ff  (acc_nmax)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign req_val_ext  = EXT_W'(req_if.value);

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.found            = rsp_found_ff;
   assign rsp_if.occurrences      = rsp_occ_ff;
   assign rsp_if.total_size       = rsp_total_ff;
   assign rsp_if.max_freq_entries = rsp_nmax_ff;
   assign rsp_if.full_drop        = rsp_drop_ff;

   assign occ_ext   = OCC_X_W'(occ_ff);
   assign total_ext = TOT_X_W'(acc_total);
   assign nmax_ext  = NMAX_X_W'(acc_nmax);

   assign eq         = (rd_val == val_ff);
   assign goes_after = order_ff ? ($signed(rd_val) < $signed(val_ff))
                                : ($signed(rd_val) > $signed(val_ff));

   // Decide what the update pass does, from the search outcome
   always_comb begin
      p_mode = UPD_KEEP;
      p_n    = n_ff;
      p_cnt  = cnt_ff;
      p_occ  = '0;
      p_drop = 1'b0;
      unique case (kind_ff)
         smc_pkg::KIND_ADD: begin
            if (found_ff) begin
               p_mode = UPD_CHANGE;
               p_cnt  = (&cnt_ff) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
               p_occ  = p_cnt;
            end else if (n_ff == NW'(CAPACITY)) begin
               p_drop = 1'b1;
            end else begin
               p_mode = UPD_INSERT;
               p_n    = n_ff + NW'(1);
               p_occ  = COUNT_BITS'(1);
            end
         end
         smc_pkg::KIND_REMOVE: begin
            if (found_ff) begin
               if (cnt_ff > COUNT_BITS'(1)) begin
                  p_mode = UPD_CHANGE;
                  p_cnt  = cnt_ff - COUNT_BITS'(1);
                  p_occ  = p_cnt;
               end else begin
                  p_mode = UPD_DELETE;
                  p_n    = n_ff - NW'(1);
               end
            end
         end
         default: begin
            if (found_ff) begin
               p_occ = cnt_ff;
            end
         end
      endcase
   end

   // Source entry of the next slot in the update pass
   always_comb begin
      nx       = (state_ff == ST_PLAN) ? '0 : idx_ff + NW'(1);
      mode_sel = (state_ff == ST_PLAN) ? p_mode : mode_ff;
      unique case (mode_sel)
         UPD_INSERT: src = (nx > pos_ff) ? nx - NW'(1) : nx;
         UPD_DELETE: src = (nx >= pos_ff) ? nx + NW'(1) : nx;
         default:    src = nx;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      new_cnt_in   = new_cnt_ff;
      occ_in       = occ_ff;
      drop_in      = drop_ff;
      order_in     = order_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_total_in = rsp_total_ff;
      rsp_nmax_in  = rsp_nmax_ff;
      rsp_drop_in  = rsp_drop_ff;
      rd_addr      = '0;
      st_wr        = '0;
      acc_ctl      = '0;

      if (csr_if.valid) begin
         order_in = csr_if.data;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_if.kind;
               val_in   = req_val_ext[VALUE_BITS-1:0];
               found_in = 1'b0;
               pos_in   = n_ff;
               idx_in   = '0;
               state_in = (n_ff == '0) ? ST_PLAN : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (eq) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
               cnt_in   = rd_cnt;
               state_in = ST_PLAN;
            end else begin
               // keep the first slot whose entry sorts after the new value
               if (goes_after && pos_ff == n_ff) begin
                  pos_in = idx_ff;
               end
               if (idx_ff == n_ff - NW'(1)) begin
                  state_in = ST_PLAN;
               end else begin
                  idx_in  = idx_ff + NW'(1);
                  rd_addr = idx_in[AW-1:0];
               end
            end
         end
         ST_PLAN: begin
            mode_in     = p_mode;
            n_in        = p_n;
            new_cnt_in  = p_cnt;
            occ_in      = p_occ;
            drop_in     = p_drop;
            idx_in      = '0;
            rd_addr     = src[AW-1:0];
            acc_ctl.clear = 1'b1;
            state_in    = (p_n == '0) ? ST_DONE : ST_UPDATE;
         end
         ST_UPDATE: begin
            st_wr.en   = 1'b1;
            st_wr.addr = idx_ff[AW-1:0];
            st_wr.val  = rd_val;
            st_wr.cnt  = rd_cnt;
            if (idx_ff == pos_ff) begin
               if (mode_ff == UPD_INSERT) begin
                  st_wr.val = val_ff;
                  st_wr.cnt = COUNT_BITS'(1);
               end else if (mode_ff == UPD_CHANGE) begin
                  st_wr.cnt = new_cnt_ff;
               end
            end
            acc_ctl.add   = 1'b1;
            acc_ctl.count = CF_W'(st_wr.cnt);
            rd_addr       = src[AW-1:0];
            if (idx_ff == n_ff - NW'(1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_occ_in   = occ_ext[smc_pkg::OCC_W-1:0];
               rsp_total_in = total_ext[smc_pkg::TOTAL_W-1:0];
               rsp_nmax_in  = nmax_ext[smc_pkg::NMAX_W-1:0];
               rsp_drop_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      cnt_ff       <= cnt_in;
      new_cnt_ff   <= new_cnt_in;
      occ_ff       <= occ_in;
      drop_ff      <= drop_in;
      rsp_found_ff <= rsp_found_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_total_ff <= rsp_total_in;
      rsp_nmax_ff  <= rsp_nmax_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(CAPACITY))
      else $error("table fill exceeds capacity");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLAN |-> pos_ff <= n_ff)
      else $error("match or insert slot beyond table fill");

   a_no_zero_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> st_wr.cnt != '0)
      else $error("zero count written into a used entry");

   a_drop_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drop_ff |-> !rsp_found_ff && rsp_occ_ff == '0)
      else $error("dropped add reports a present value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("sequencer idle right after an accept");
`endif

endmodule
